[hw/rtl/cqs_pkg.sv]
package cqs_pkg;

  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_DEQ    = 3'd1;
  localparam logic [2:0] CMD_SEARCH = 3'd2;
  localparam logic [2:0] CMD_SLOT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 4;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
    logic [SLOT_W-1:0]        slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     found;
    logic signed [WORD_W-1:0] front_value;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

endpackage

[hw/rtl/cqs_stream_if.sv]
interface cqs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/circular_queue_with_search_top.sv]
// Circular FIFO of signed 32-bit words with value search and slot query.
// req channel: one request per item (command, value, slot_index); rsp
// channel: one result per request (status, data, found, front_value, count).
// Both channels use valid/ready; a transfer happens when both are high.
// Holds at most DEPTH-1 words; one storage slot always stays unused.
// A request is taken only when the sequencer is idle. Every request passes
// through the execute, front read and final states; a dequeue adds a state
// that takes the read word and advances head, and a search walks the entries
// until a hit or the tail. The next request is taken only after the result
// is loaded, so a new item is not accepted before the last one is done. The
// pace is set by the single read port of the storage RAM (one entry per cycle
// during a search) plus the read of the new head entry that every result reports.
// The result sits in an output register; the next request is accepted while
// it waits. If rsp is stalled when a second result is ready, the sequencer
// holds in its final state until the register frees.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// storage contents are not cleared, and an unwritten entry never reaches a result.
module circular_queue_with_search_top #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  cqs_stream_if.sink   req,
  cqs_stream_if.source rsp
);
  import cqs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // one bit of headroom so DEPTH itself fits in the compare width
  localparam int CW = ((PW > SLOT_W) ? PW : SLOT_W) + 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DEQ, S_SEARCH, S_FRONT, S_FIN
  } state_t;

  state_t            state;
  logic [PW-1:0]     head, tail, ptr;
  logic [2:0]        cmd_q;
  logic [WORD_W-1:0] val_q;
  logic [SLOT_W-1:0] slot_q;
  logic [1:0]        status_q;
  logic [WORD_W-1:0] data_q;
  logic              found_q;

  logic              wr_en, rd_en;
  logic [PW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic              empty, full, slot_hit, hit, load_rsp;
  logic [PW-1:0]     head_adv, tail_adv, ptr_adv;
  logic [CW-1:0]     held_w, slot_w, head_w, tail_w;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  assign head_adv = advance(head);
  assign tail_adv = advance(tail);
  assign ptr_adv  = advance(ptr);
  assign empty    = (head == tail);
  assign full     = (tail_adv == head);
  assign hit      = (rd_data == val_q);
  assign load_rsp = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign head_w = CW'(head);
  assign tail_w = CW'(tail);
  assign slot_w = CW'(slot_q);
  assign held_w = (tail_w >= head_w) ? tail_w - head_w : CW'(DEPTH) - (head_w - tail_w);

  always_comb begin
    if (slot_w >= CW'(DEPTH)) begin
      slot_hit = 1'b0;
    end else if (head_w <= tail_w) begin
      slot_hit = (slot_w >= head_w) && (slot_w < tail_w);
    end else begin
      slot_hit = (slot_w >= head_w) || (slot_w < tail_w);
    end
  end

  // RAM port control
  always_comb begin
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      S_EXEC: begin
        wr_en = (cmd_q == CMD_ENQ) && !full;
        rd_en = ((cmd_q == CMD_DEQ) || (cmd_q == CMD_SEARCH)) && !empty;
      end
      S_SEARCH: begin
        rd_en   = !hit && (ptr != tail);
        rd_addr = ptr;
      end
      S_FRONT: rd_en = 1'b1;
      default: ;
    endcase
  end

  cqs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (val_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q    <= req.payload.command;
            val_q    <= req.payload.value;
            slot_q   <= req.payload.slot_index;
            status_q <= ST_OK;
            data_q   <= '0;
            found_q  <= 1'b0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FRONT;
          case (cmd_q)
            CMD_ENQ: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                tail <= tail_adv;
              end
            end
            CMD_DEQ: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                state <= S_DEQ;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                ptr   <= head_adv;
                state <= S_SEARCH;
              end
            end
            CMD_SLOT: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                found_q <= slot_hit;
              end
            end
            CMD_CLEAR: begin
              head <= '0;
              tail <= '0;
            end
            default: ;
          endcase
        end
        S_DEQ: begin
          data_q <= rd_data;
          head   <= head_adv;
          state  <= S_FRONT;
        end
        S_SEARCH: begin
          // rd_data holds the entry just before ptr
          if (hit) begin
            found_q <= 1'b1;
            state   <= S_FRONT;
          end else if (ptr == tail) begin
            state <= S_FRONT;
          end else begin
            ptr <= ptr_adv;
          end
        end
        S_FRONT: state <= S_FIN;
        S_FIN: begin
          if (load_rsp) begin
            rsp.payload.status      <= status_q;
            rsp.payload.data        <= data_q;
            rsp.payload.found       <= found_q;
            rsp.payload.front_value <= empty ? '0 : rd_data;
            rsp.payload.count       <= held_w[COUNT_W-1:0];
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head <= LAST) && (tail <= LAST))
    else $error("queue pointer beyond storage");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (head != tail))
    else $error("search walk on an empty queue");

  a_enq_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd_q == CMD_ENQ && !full) |=> (tail == advance($past(tail))))
    else $error("tail did not advance after enqueue");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside final state");

  a_deq_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |=> (head == advance($past(head))) && (tail == $past(tail)))
    else $error("dequeue pointer update wrong");
endmodule

[hw/rtl/cqs_ram.sv]
module cqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[tb/cqs_queue_checker.sv]
`timescale 1ns / 1ps
module cqs_queue_checker
  import cqs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_payload,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_payload,
  output int   mismatches,
  output int   awaiting
);

  localparam int SLOTS         = 16;
  localparam int MAX_ERR_LINES = 40;

  logic [WORD_W-1:0] slot_words [SLOTS];
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr;
  rsp_t              awaited_results [$];
  int                mismatch_cnt = 0;
  int                awaited_cnt  = 0;
  int                result_idx   = 0;

  assign mismatches = mismatch_cnt;
  assign awaiting   = awaited_cnt;

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < MAX_ERR_LINES) $display("ERROR: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_idx, name, got, want));
  endtask

  // Applies one request to the queue copy and returns the result it must produce.
  function automatic rsp_t queue_step(req_t r);
    rsp_t              res;
    logic [SLOT_W-1:0] next_tail;
    logic [SLOT_W-1:0] p;
    logic              is_empty;
    res        = '0;
    res.status = ST_OK;
    is_empty   = (head_ptr == tail_ptr);
    case (r.command)
      CMD_ENQ: begin
        next_tail = tail_ptr + 1'b1;
        if (next_tail == head_ptr) begin
          res.status = ST_FULL;
        end else begin
          slot_words[tail_ptr] = r.value;
          tail_ptr = next_tail;
        end
      end
      CMD_DEQ: begin
        if (is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = slot_words[head_ptr];
          head_ptr = head_ptr + 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          for (p = head_ptr; p != tail_ptr; p = p + 1'b1)
            if (slot_words[p] == r.value) res.found = 1'b1;
        end
      end
      CMD_SLOT: begin
        // occupied when its distance from head is below the entry count
        if (is_empty) res.status = ST_EMPTY;
        else res.found = (SLOT_W'(r.slot_index - head_ptr) < SLOT_W'(tail_ptr - head_ptr));
      end
      CMD_CLEAR: begin
        head_ptr = '0;
        tail_ptr = '0;
      end
      default: ;
    endcase
    res.front_value = (head_ptr != tail_ptr) ? slot_words[head_ptr] : '0;
    res.count       = tail_ptr - head_ptr;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      head_ptr = '0;
      tail_ptr = '0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request awaiting it",
                                    result_idx));
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(rsp_payload.status), 32'(want.status));
          check_field("data", rsp_payload.data, want.data);
          check_field("found", 32'(rsp_payload.found), 32'(want.found));
          check_field("front_value", rsp_payload.front_value, want.front_value);
          check_field("count", 32'(rsp_payload.count), 32'(want.count));
        end
        result_idx++;
      end
      if (req_valid && req_ready) awaited_results.push_back(queue_step(req_payload));
    end
    awaited_cnt = awaited_results.size();
  end

endmodule

[tb/tb_circular_queue_with_search_top.sv]
`timescale 1ns / 1ps
module tb_circular_queue_with_search_top;
  import cqs_pkg::*;

  localparam int QUIET_LIMIT      = 3000;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 430;
  localparam int RECENT_KEEP      = 20;
  localparam int TAIL_CYCLES      = 40;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cqs_stream_if #(.payload_t(req_t)) req_if ();
  cqs_stream_if #(.payload_t(rsp_t)) rsp_if ();

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int mismatches;
  int awaiting;

  logic signed [WORD_W-1:0] recent_words [$];

  always #10 clk = ~clk;

  circular_queue_with_search_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  cqs_queue_checker queue_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_payload (req_if.payload),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_payload (rsp_if.payload),
    .mismatches  (mismatches),
    .awaiting    (awaiting)
  );

  // result sink: random stalls, plus a long hold-off when one is asked for
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready && !rst) results_seen++;
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, awaiting);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(WORD_W-1){1'b0}}};
      1:       return {1'b0, {(WORD_W-1){1'b1}}};
      2:       return WORD_W'($urandom_range(0, 3));
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    return SLOT_W'($urandom_range(0, 15));
  endfunction

  // mostly words still likely to be queued, so searches hit often
  function automatic logic [WORD_W-1:0] search_word();
    if (recent_words.size() != 0 && $urandom_range(0, 2) != 0)
      return recent_words[$urandom_range(0, recent_words.size() - 1)];
    return rand_word();
  endfunction

  task automatic send_req(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    requests_sent++;
    if (r.command == CMD_ENQ) begin
      recent_words.push_back(r.value);
      if (recent_words.size() > RECENT_KEEP) void'(recent_words.pop_front());
    end
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [WORD_W-1:0] word, logic [SLOT_W-1:0] slot);
    req_t r;
    r.command    = cmd;
    r.value      = word;
    r.slot_index = slot;
    send_req(r);
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic random_phase(int n_items);
    int done_items;
    int len;
    int pick;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        len = $urandom_range(1, 18);
        repeat (len) send_cmd(CMD_ENQ, rand_word(), rand_slot());
        done_items += len;
      end else if (pick < 48) begin
        len = $urandom_range(1, 18);
        repeat (len) send_cmd(CMD_DEQ, rand_word(), rand_slot());
        done_items += len;
      end else if (pick < 88) begin
        case ($urandom_range(0, 4))
          0:       send_cmd(CMD_ENQ, rand_word(), rand_slot());
          1:       send_cmd(CMD_DEQ, rand_word(), rand_slot());
          4:       send_cmd(CMD_SLOT, rand_word(), rand_slot());
          default: send_cmd(CMD_SEARCH, search_word(), rand_slot());
        endcase
        done_items++;
      end else if (pick < 93) begin
        send_cmd(CMD_CLEAR, rand_word(), rand_slot());
        done_items++;
      end else begin
        send_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), rand_word(),
                 rand_slot());
      end
    end
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-queue cases, extremes, hits and misses, spare codes, clear
    send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_SEARCH, '0, '0);
    send_cmd(CMD_SLOT, '0, '0);
    send_cmd(CMD_ENQ, 32'h8000_0000, '0);
    send_cmd(CMD_ENQ, 32'h7FFF_FFFF, '1);
    send_cmd(CMD_ENQ, '0, '0);
    send_cmd(CMD_ENQ, '1, '1);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF, '0);
    send_cmd(CMD_SEARCH, 32'd12345, '0);
    send_cmd(CMD_SLOT, '0, 4'd0);
    send_cmd(CMD_SLOT, '0, 4'd15);
    send_cmd(CMD_SLOT, '0, 4'd4);
    send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_SPARE_FIRST, '1, '1);
    send_cmd(CMD_SPARE_FIRST + 3'd1, '0, '0);
    send_cmd(CMD_SPARE_LAST, '1, '1);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_SLOT, '0, 4'd0);
    send_cmd(CMD_ENQ, 32'hAAAA_AAAA, 4'd5);
    send_cmd(CMD_ENQ, 32'h5555_5555, 4'd10);
    send_cmd(CMD_SEARCH, 32'h5555_5555, '0);
    send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_DEQ, '0, '0);

    random_phase(RANDOM_PER_PHASE);

    // sink holds off while requests keep coming, so the block backs up
    holds_asked++;
    repeat (24) send_cmd(CMD_ENQ, rand_word(), rand_slot());
    drain();

    send_idle_pct = 74;
    rsp_stall_pct = 0;
    random_phase(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 0;
    rsp_stall_pct = 74;
    random_phase(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 25;
    rsp_stall_pct = 25;
    random_phase(RANDOM_PER_PHASE);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d requests (fill, drain, wrap, search, slot query, clear, spare codes)",
             requests_sent);
    $display("under four idle/stall mixes and a %0d-cycle sink hold; %0d results, %0d mismatches",
             HOLD_CYCLES, results_seen, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[circular_queue_with_search_top.f]
hw/rtl/cqs_pkg.sv
hw/rtl/cqs_stream_if.sv
hw/rtl/cqs_ram.sv
hw/rtl/circular_queue_with_search_top.sv
tb/cqs_queue_checker.sv
tb/tb_circular_queue_with_search_top.sv
